>>> rtl/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants for the window range statistics block
// Item and result words, back-end states and fixed field widths.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // Default depth of one window.
  localparam int unsigned MAX_SAMPLES_DEF = 1024;

  // Fixed field widths.
  localparam int DIST_W  = 24;
  localparam int SQ_W    = 2 * DIST_W - 1;
  localparam int WIN_W   = 16;
  localparam int TOTAL_W = 11;
  localparam int OUT_W   = 24;

  // Rate scale: samples per second times 16 from milliseconds.
  localparam int RATE_SCALE = 16000;
  localparam int RATE_K_W   = 14;

  localparam logic [OUT_W-1:0]         SAT24    = '1;
  localparam logic signed [DIST_W-1:0] MIN_INIT = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] MAX_INIT = 24'sh800000;

  typedef enum logic [0:0] {
    MODE_SAMPLE = 1'b0,
    MODE_CLOSE  = 1'b1
  } mode_e;

  // Classified input word, with the square of the sample magnitude.
  typedef struct packed {
    mode_e                    mode;
    logic signed [DIST_W-1:0] distance;
    logic [SQ_W-1:0]          sq;
    logic [WIN_W-1:0]         window_ms;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]      sample_total;
    logic signed [OUT_W-1:0] mean_value;
    logic [OUT_W-1:0]        deviation;
    logic [OUT_W-1:0]        spread;
    logic [OUT_W-1:0]        rate_x16;
    logic                    dropped;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_DIVV,
    B_SQRT,
    B_DIVM,
    B_DIVR,
    B_DONE
  } back_state_e;

endpackage

>>> rtl/wrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_front: input stage
// Takes input words, decodes the mode and squares the sample magnitude.
// ----------------------------------------------------------------------------
module wrs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          mode_i,
  input  logic signed [wrs_pkg::DIST_W-1:0] distance_i,
  input  logic [wrs_pkg::WIN_W-1:0]     window_ms_i,
  output logic                          item_valid_o,
  output wrs_pkg::item_t                item_o,
  input  logic                          q_full_i
);
  import wrs_pkg::*;

  logic                stage_v_q;
  item_t               stage_q;
  logic [DIST_W-1:0]   mag;
  logic                take;
  logic                move;

  // The stage drains into the queue whenever the queue has room.
  assign move         = stage_v_q && !q_full_i;
  assign full_o       = stage_v_q && q_full_i;
  assign take         = push_i && !full_o;
  assign item_valid_o = stage_v_q;
  assign item_o       = stage_q;

  // Magnitude of the sample; the most negative value still fits unsigned.
  assign mag = distance_i[DIST_W-1] ? DIST_W'(-distance_i) : DIST_W'(distance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (take) begin
      stage_v_q <= 1'b1;
    end else if (move) begin
      stage_v_q <= 1'b0;
    end
  end

  // Payload of the stage register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q.mode      <= mode_e'(mode_i);
      stage_q.distance  <= distance_i;
      stage_q.sq        <= SQ_W'(mag * mag);
      stage_q.window_ms <= window_ms_i;
    end
  end

endmodule

>>> rtl/wrs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_fifo: two-entry item queue
// Decouples the input stage from the statistics engine.
// ----------------------------------------------------------------------------
module wrs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  wrs_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output wrs_pkg::item_t rdata_o
);
  import wrs_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q;
  logic        rptr_q;
  logic [1:0]  cnt_q;
  logic        do_wr;
  logic        do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_q <= !wptr_q;
      end
      if (do_rd) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/wrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_div: restoring divider
// One quotient bit per cycle; a zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module wrs_div #(
  parameter int W  = 69,
  parameter int DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quotient_o
);
  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    dvd_q;
  logic [DW-1:0]   dsr_q;
  logic [DW:0]     rem_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW:0]     rem_sh;
  logic            ge;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh     = {rem_q[DW-1:0], dvd_q[W-1]};
  assign ge         = rem_sh >= {1'b0, dsr_q};
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient bits replace dividend bits in the same register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      dvd_q <= {dvd_q[W-2:0], ge};
    end
  end

endmodule

>>> rtl/wrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_back: statistics engine
// Accumulates samples and, on a window close, runs the serial multiply,
// divide and square root sequence that forms one result word.
// ----------------------------------------------------------------------------
module wrs_back #(
  parameter int unsigned MAX_SAMPLES = wrs_pkg::MAX_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  wrs_pkg::item_t    item_i,
  output logic              item_pop_o,
  input  logic              res_pop_i,
  output logic              res_valid_o,
  output wrs_pkg::result_t  res_o
);
  import wrs_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = DIST_W + CW;
  localparam int QW   = SQ_W + CW;
  localparam int NW   = QW + CW;
  localparam int SQW  = NW + (NW % 2);
  localparam int HW   = SQW / 2;
  localparam int RW   = HW + 2;
  localparam int DVW  = (2 * CW > WIN_W) ? 2 * CW : WIN_W;
  localparam int STW  = $clog2(NW + 2);
  localparam int RNW  = CW + RATE_K_W;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SAMPLES);

  back_state_e state_q, state_d;

  // Accumulators.
  logic [CW-1:0]            cnt_q;
  logic signed [SW-1:0]     sum_q;
  logic [QW-1:0]            sq_q;
  logic signed [DIST_W-1:0] min_q;
  logic signed [DIST_W-1:0] max_q;
  logic                     ovf_q;

  // Close sequence datapath.
  logic [STW-1:0]   step_q;
  logic [NW-1:0]    mcand_q;
  logic [SW-1:0]    mplier_q;
  logic [NW-1:0]    prod_q;
  logic [NW-1:0]    num_q;
  logic [2*CW-1:0]  nn1_q;
  logic [WIN_W-1:0] win_q;
  logic [SQW-1:0]   var_q;
  logic [HW-1:0]    root_q;
  logic [RW-1:0]    rem_q;
  logic [OUT_W-1:0] mean_q;
  logic [OUT_W-1:0] rate_q;
  logic             div_run_q;

  logic             res_v_q;
  result_t          res_q;

  logic             is_div;
  logic             div_start;
  logic             div_done;
  logic [NW-1:0]    div_dvd;
  logic [DVW-1:0]   div_dsr;
  logic [NW-1:0]    div_quo;
  logic [SW-1:0]    smag;
  logic [NW-1:0]    prod_nx;
  logic             last_step;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             take_sample;
  logic             take_close;
  logic [RNW-1:0]   rate_num;
  logic [OUT_W-1:0] quo_lo;
  logic [OUT_W-1:0] dev_val;

  assign smag        = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign prod_nx     = mplier_q[0] ? (prod_q + mcand_q) : prod_q;
  assign last_step   = (step_q == STW'(1));
  assign rem_sh      = {rem_q[RW-3:0], var_q[SQW-1:SQW-2]};
  assign trial       = {root_q, 2'b01};
  assign rate_num    = RNW'(cnt_q) * RNW'(RATE_SCALE);
  assign quo_lo      = div_quo[OUT_W-1:0];
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // Square root result, forced to zero below two samples and saturated.
  always_comb begin
    if (cnt_q < CW'(2)) begin
      dev_val = '0;
    end else if (root_q > HW'(SAT24)) begin
      dev_val = SAT24;
    end else begin
      dev_val = OUT_W'(root_q);
    end
  end

  // Divider operands by step of the sequence.
  always_comb begin
    div_dvd = num_q;
    div_dsr = DVW'(nn1_q);
    case (state_q)
      B_DIVM: begin
        div_dvd = NW'(smag);
        div_dsr = DVW'(cnt_q);
      end
      B_DIVR: begin
        div_dvd = NW'(rate_num);
        div_dsr = DVW'(win_q);
      end
      default: begin
        div_dvd = num_q;
        div_dsr = DVW'(nn1_q);
      end
    endcase
  end

  assign is_div    = (state_q == B_DIVV) || (state_q == B_DIVM) || (state_q == B_DIVR);
  assign div_start = is_div && !div_run_q;

  wrs_div #(
    .W  (NW),
    .DW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Next state and queue pop.
  always_comb begin
    state_d     = state_q;
    take_sample = 1'b0;
    take_close  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (item_valid_i) begin
          if (item_i.mode == MODE_CLOSE) begin
            take_close = 1'b1;
            state_d    = B_MUL1;
          end else begin
            take_sample = 1'b1;
          end
        end
      end
      B_MUL1: begin
        if (last_step) begin
          state_d = B_MUL2;
        end
      end
      B_MUL2: begin
        if (last_step) begin
          state_d = B_DIVV;
        end
      end
      B_DIVV: begin
        if (div_done) begin
          state_d = B_SQRT;
        end
      end
      B_SQRT: begin
        if (last_step) begin
          state_d = B_DIVM;
        end
      end
      B_DIVM: begin
        if (div_done) begin
          state_d = B_DIVR;
        end
      end
      B_DIVR: begin
        if (div_done) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!res_v_q) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign item_pop_o = take_sample || take_close;

  // State, accumulators and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      cnt_q     <= '0;
      sum_q     <= '0;
      sq_q      <= '0;
      min_q     <= MIN_INIT;
      max_q     <= MAX_INIT;
      ovf_q     <= 1'b0;
      res_v_q   <= 1'b0;
      div_run_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        div_run_q <= 1'b1;
      end else if (div_done) begin
        div_run_q <= 1'b0;
      end
      if (take_sample) begin
        if (cnt_q >= MaxCnt) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          sum_q <= sum_q + SW'(item_i.distance);
          sq_q  <= sq_q + QW'(item_i.sq);
          if (item_i.distance < min_q) begin
            min_q <= item_i.distance;
          end
          if (item_i.distance > max_q) begin
            max_q <= item_i.distance;
          end
        end
      end
      if (state_q == B_DONE && !res_v_q) begin
        res_v_q <= 1'b1;
        cnt_q   <= '0;
        sum_q   <= '0;
        sq_q    <= '0;
        min_q   <= MIN_INIT;
        max_q   <= MAX_INIT;
        ovf_q   <= 1'b0;
      end else if (res_pop_i && res_v_q) begin
        res_v_q <= 1'b0;
      end
    end
  end

  // Close sequence datapath: shift-add products, root digits, captures.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (take_close) begin
          win_q    <= item_i.window_ms;
          nn1_q    <= (2*CW)'(cnt_q) * (2*CW)'(cnt_q - 1'b1);
          mcand_q  <= NW'(sq_q);
          mplier_q <= SW'(cnt_q);
          prod_q   <= '0;
          step_q   <= STW'(SW);
        end
      end
      B_MUL1: begin
        if (last_step) begin
          num_q    <= prod_nx;
          mcand_q  <= NW'(smag);
          mplier_q <= smag;
          prod_q   <= '0;
          step_q   <= STW'(SW);
        end else begin
          step_q   <= step_q - 1'b1;
          mcand_q  <= {mcand_q[NW-2:0], 1'b0};
          mplier_q <= mplier_q >> 1;
          prod_q   <= prod_nx;
        end
      end
      B_MUL2: begin
        step_q   <= step_q - 1'b1;
        mcand_q  <= {mcand_q[NW-2:0], 1'b0};
        mplier_q <= mplier_q >> 1;
        prod_q   <= prod_nx;
        if (last_step) begin
          num_q <= num_q - prod_nx;
        end
      end
      B_DIVV: begin
        if (div_done) begin
          var_q  <= SQW'(div_quo);
          root_q <= '0;
          rem_q  <= '0;
          step_q <= STW'(HW);
        end
      end
      B_SQRT: begin
        step_q <= step_q - 1'b1;
        var_q  <= {var_q[SQW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[HW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[HW-2:0], 1'b0};
        end
      end
      B_DIVM: begin
        if (div_done) begin
          mean_q <= sum_q[SW-1] ? OUT_W'(-quo_lo) : quo_lo;
        end
      end
      B_DIVR: begin
        if (div_done) begin
          rate_q <= (div_quo > NW'(SAT24)) ? SAT24 : quo_lo;
        end
      end
      B_DONE: begin
        if (!res_v_q) begin
          res_q.sample_total <= TOTAL_W'(cnt_q);
          res_q.dropped      <= ovf_q;
          if (cnt_q == '0) begin
            res_q.mean_value <= '0;
            res_q.deviation  <= '0;
            res_q.spread     <= '0;
            res_q.rate_x16   <= '0;
          end else begin
            res_q.mean_value <= mean_q;
            res_q.deviation  <= dev_val;
            res_q.spread     <= OUT_W'(max_q - min_q);
            res_q.rate_x16   <= rate_q;
          end
        end
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

endmodule

>>> rtl/window_range_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_range_statistics: windowed count, mean, deviation and spread
// Collects distance samples per window and reports statistics on close.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        mode_i, distance_i, window_ms_i
//  result    empty / pop        sample_total_o, mean_value_o, deviation_o,
//                               spread_o, rate_x16_o, dropped_o
//
// A sample word is taken every cycle while full is low; it passes the input
// stage register and the two-entry queue and is folded into the sums at the
// edge that takes it out of the queue. A close word runs a serial multiplier,
// the shared restoring divider three times and a two-bit-per-step square root.
// Reset clears the control state and accumulators only. A result waits
// in its own register until popped; samples keep flowing meanwhile, and a
// following close runs its sequence and then holds until the register frees.
// ----------------------------------------------------------------------------
module window_range_statistics #(
  parameter int unsigned MAX_SAMPLES = wrs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               mode_i,
  input  logic signed [wrs_pkg::DIST_W-1:0]  distance_i,
  input  logic [wrs_pkg::WIN_W-1:0]          window_ms_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [wrs_pkg::TOTAL_W-1:0]        sample_total_o,
  output logic signed [wrs_pkg::OUT_W-1:0]   mean_value_o,
  output logic [wrs_pkg::OUT_W-1:0]          deviation_o,
  output logic [wrs_pkg::OUT_W-1:0]          spread_o,
  output logic [wrs_pkg::OUT_W-1:0]          rate_x16_o,
  output logic                               dropped_o
);
  import wrs_pkg::*;

  logic    stage_v;
  item_t   stage_item;
  logic    q_full;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  logic    res_v;
  result_t res;

  // Front: input stage.
  wrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .mode_i       (mode_i),
    .distance_i   (distance_i),
    .window_ms_i  (window_ms_i),
    .item_valid_o (stage_v),
    .item_o       (stage_item),
    .q_full_i     (q_full)
  );

  // Queue between front and back.
  wrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (stage_v),
    .wdata_i (stage_item),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_item)
  );

  // Back: statistics engine.
  wrs_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_pop_i    (pop),
    .res_valid_o  (res_v),
    .res_o        (res)
  );

  assign empty          = !res_v;
  assign sample_total_o = res.sample_total;
  assign mean_value_o   = res.mean_value;
  assign deviation_o    = res.deviation;
  assign spread_o       = res.spread;
  assign rate_x16_o     = res.rate_x16;
  assign dropped_o      = res.dropped;

  // Full is only raised when the queue behind the stage is full too.
  a_full_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_full)
    else $error("full raised while the queue has room");

  // The back only pops the queue when it holds a word.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  if (MAX_SAMPLES < 2048) begin : g_chk
    // An empty window reports zeros.
    a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && sample_total_o == '0) |->
        (mean_value_o == '0 && deviation_o == '0 && spread_o == '0 &&
         rate_x16_o == '0))
      else $error("empty window with nonzero statistics");

    // A single sample has no deviation and no spread.
    a_single_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!empty && sample_total_o == TOTAL_W'(1)) |->
        (deviation_o == '0 && spread_o == '0))
      else $error("single sample with nonzero deviation or spread");
  end

endmodule

>>> dv/wrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_checker: predictor and scoreboard for window_range_statistics
// Watches both queue channels, keeps its own copy of the window sums and
// compares every popped statistics word against the predicted one.
// ----------------------------------------------------------------------------
module wrs_checker #(
  parameter int unsigned MAX_SAMPLES = wrs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic                              full_i,
  input  logic                              mode_i,
  input  logic signed [wrs_pkg::DIST_W-1:0] distance_i,
  input  logic [wrs_pkg::WIN_W-1:0]         window_ms_i,
  input  logic                              empty_i,
  input  logic                              pop_i,
  input  logic [wrs_pkg::TOTAL_W-1:0]       sample_total_i,
  input  logic signed [wrs_pkg::OUT_W-1:0]  mean_value_i,
  input  logic [wrs_pkg::OUT_W-1:0]         deviation_i,
  input  logic [wrs_pkg::OUT_W-1:0]         spread_i,
  input  logic [wrs_pkg::OUT_W-1:0]         rate_x16_i,
  input  logic                              dropped_i,
  output int                                mismatch_count_o,
  output int                                stats_pending_o,
  output int                                stats_checked_o,
  output int                                samples_seen_o
);
  import wrs_pkg::*;

  // Window accumulators of the predictor.
  longint unsigned win_count;
  longint          win_sum;
  logic [127:0]    win_sq_sum;
  longint          win_min;
  longint          win_max;
  logic            win_dropped;
  result_t         stats_q[$];

  // Floor of the square root, one result bit per step.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // Statistics of the window that a close word ends.
  function automatic result_t close_stats(input logic [WIN_W-1:0] win);
    result_t         r;
    logic [127:0]    num;
    logic [127:0]    mag;
    longint unsigned var_q;
    longint unsigned rate;
    longint unsigned dev;
    r = '0;
    r.dropped = win_dropped;
    if (win_count != 0) begin
      r.sample_total = win_count[TOTAL_W-1:0];
      r.mean_value   = OUT_W'(win_sum / longint'(win_count));
      r.spread       = OUT_W'(win_max - win_min);
      if (win == 0) begin
        r.rate_x16 = SAT24;
      end else begin
        rate = (win_count * RATE_SCALE) / win;
        r.rate_x16 = (rate > SAT24) ? SAT24 : OUT_W'(rate);
      end
      if (win_count >= 2) begin
        mag   = (win_sum < 0) ? 128'(-win_sum) : 128'(win_sum);
        num   = 128'(win_count) * win_sq_sum - mag * mag;
        var_q = 64'(num / (128'(win_count) * 128'(win_count - 1)));
        dev   = floor_sqrt(var_q);
        r.deviation = (dev > SAT24) ? SAT24 : OUT_W'(dev);
      end
    end
    return r;
  endfunction

  function automatic void clear_window();
    win_count   = 0;
    win_sum     = 0;
    win_sq_sum  = '0;
    win_min     = 8388607;
    win_max     = -8388608;
    win_dropped = 1'b0;
  endfunction

  initial clear_window();

  assign stats_pending_o = stats_q.size();

  // Fold accepted words into the window and compare popped words.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_w;
    result_t got;
    longint  d;
    if (!rst_ni) begin
      clear_window();
      stats_q.delete();
      mismatch_count_o <= 0;
      stats_checked_o  <= 0;
      samples_seen_o   <= 0;
    end else begin
      if (push_i && !full_i) begin
        if (mode_e'(mode_i) == MODE_SAMPLE) begin
          samples_seen_o <= samples_seen_o + 1;
          d = distance_i;
          if (win_count >= MAX_SAMPLES) begin
            win_dropped = 1'b1;
          end else begin
            win_count++;
            win_sum += d;
            win_sq_sum += 128'(d * d);
            if (d < win_min) win_min = d;
            if (d > win_max) win_max = d;
          end
        end else begin
          stats_q.insert(stats_q.size(), close_stats(window_ms_i));
          clear_window();
        end
      end
      if (pop_i && !empty_i) begin
        got = '{sample_total_i, mean_value_i, deviation_i, spread_i, rate_x16_i,
                dropped_i};
        stats_checked_o <= stats_checked_o + 1;
        if (stats_q.size() == 0) begin
          mismatch_count_o <= mismatch_count_o + 1;
          if (mismatch_count_o < 10)
            $display("%0t: statistics word with none predicted: %p", $realtime, got);
        end else begin
          exp_w = stats_q.pop_front();
          if (got !== exp_w) begin
            mismatch_count_o <= mismatch_count_o + 1;
            if (mismatch_count_o < 10)
              $display("%0t: statistics word differs\n  expected %p\n  actual   %p",
                       $realtime, exp_w, got);
          end
        end
      end
    end
  end

endmodule

>>> dv/window_range_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_range_statistics_tb: stimulus and verdict for window statistics
// Sends directed and random sample windows with random gaps and pop stalls;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module window_range_statistics_tb;
  import wrs_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 500;

  logic                     clk;
  logic                     rst_n;
  logic                     push;
  logic                     full;
  logic                     mode;
  logic signed [DIST_W-1:0] distance;
  logic [WIN_W-1:0]         window_ms;
  logic                     empty;
  logic                     pop;
  logic [TOTAL_W-1:0]       sample_total;
  logic signed [OUT_W-1:0]  mean_value;
  logic [OUT_W-1:0]         deviation;
  logic [OUT_W-1:0]         spread;
  logic [OUT_W-1:0]         rate_x16;
  logic                     dropped;
  int                       mismatches;
  int                       pending;
  int                       stats_checked;
  int                       samples_seen;
  int                       cycles;
  int                       windows_sent;
  int                       items_sent;
  int                       pop_hold;
  bit                       pop_bursty;

  window_range_statistics dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .mode_i(mode),
    .distance_i(distance), .window_ms_i(window_ms), .empty(empty), .pop(pop),
    .sample_total_o(sample_total), .mean_value_o(mean_value),
    .deviation_o(deviation), .spread_o(spread), .rate_x16_o(rate_x16),
    .dropped_o(dropped)
  );

  wrs_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .mode_i(mode),
    .distance_i(distance), .window_ms_i(window_ms), .empty_i(empty), .pop_i(pop),
    .sample_total_i(sample_total), .mean_value_i(mean_value),
    .deviation_i(deviation), .spread_i(spread), .rate_x16_i(rate_x16),
    .dropped_i(dropped), .mismatch_count_o(mismatches),
    .stats_pending_o(pending), .stats_checked_o(stats_checked),
    .samples_seen_o(samples_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3, 4: return DIST_W'($signed($urandom_range(0, 4000)) - 2000);
      default: return DIST_W'($urandom);
    endcase
  endfunction

  // Drive one word and hold it until the block takes it.
  task automatic send_word(input mode_e m, input logic signed [DIST_W-1:0] d,
                           input logic [WIN_W-1:0] w);
    int gap;
    push      <= 1'b1;
    mode      <= m;
    distance  <= d;
    window_ms <= w;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    items_sent++;
    gap = idle_length();
    if (gap > 0) begin
      push     <= 1'b0;
      distance <= DIST_W'($urandom);
      repeat (gap - 1) @(posedge clk);
      if (gap > 1) @(posedge clk);
      else @(posedge clk);
    end
  endtask

  task automatic close_window(input logic [WIN_W-1:0] w);
    send_word(MODE_CLOSE, DIST_W'($urandom), w);
    windows_sent++;
  endtask

  task automatic random_window(input int n_samples);
    for (int i = 0; i < n_samples; i++)
      send_word(MODE_SAMPLE, pick_distance(), WIN_W'($urandom));
    case ($urandom_range(0, 9))
      0: close_window('0);
      1: close_window('1);
      2: close_window(WIN_W'($urandom_range(1, 5)));
      default: close_window(WIN_W'($urandom));
    endcase
  endtask

  // Result side: pop with stalls; some stretches never stall.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pop        <= 1'b0;
      pop_bursty <= 1'b0;
      pop_hold   <= 0;
    end else if (pop_hold != 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      pop_bursty <= ~pop_bursty;
    end else if (!pop_bursty) begin
      pop <= 1'b1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= idle_length();
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d result words outstanding", pending);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int n;
    windows_sent = 0;
    items_sent   = 0;
    rst_n        = 1'b0;
    push         = 1'b0;
    mode         = 1'b0;
    distance     = '0;
    window_ms    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty window, single sample with a zero window, full-scale
    // spread, and a window that overruns the sample store.
    close_window(16'd5);
    send_word(MODE_SAMPLE, 24'sh7FFFFF, '0);
    close_window('0);
    send_word(MODE_SAMPLE, 24'sh800000, '0);
    send_word(MODE_SAMPLE, 24'sh7FFFFF, '0);
    close_window('1);
    send_word(MODE_SAMPLE, 24'sh800000, '0);
    send_word(MODE_SAMPLE, 24'sh800000, '0);
    send_word(MODE_SAMPLE, 24'sh800000, '0);
    close_window(16'd1);
    send_word(MODE_SAMPLE, -24'sd3, '0);
    send_word(MODE_SAMPLE, 24'sd0, '0);
    close_window(16'd3);
    for (int i = 0; i < MAX_SAMPLES_DEF + 6; i++)
      send_word(MODE_SAMPLE, (i % 2) ? 24'sh7FFFFF : 24'sh800000, '0);
    close_window(16'd1);
    close_window(16'd7);

    // Random windows, mostly short, a few longer ones.
    while (items_sent < 1400) begin
      case ($urandom_range(0, 29))
        0: n = $urandom_range(31, 80);
        1, 2: n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 30);
      endcase
      random_window(n);
    end
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples in %0d windows; checked %0d statistics words.",
             samples_seen, windows_sent, stats_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wrs_pkg.sv
rtl/wrs_front.sv
rtl/wrs_fifo.sv
rtl/wrs_div.sv
rtl/wrs_back.sv
rtl/window_range_statistics.sv
dv/wrs_checker.sv
dv/window_range_statistics_tb.sv
